// ===== design/gsm_pkg.sv =====
`timescale 1ns / 1ps

package gsm_pkg;

    localparam int SLOTS     = 64;
    localparam int DATA_BITS = 32;
    localparam int GEN_BITS  = 16;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_GET    = 2'd1,
        FN_REMOVE = 2'd2,
        FN_ALIVE  = 2'd3
    } t_func;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        RES_FULL,
        RES_BAD,
        RES_OK,
        RES_INS,
        RES_GET
    } t_res_sel;

    typedef struct packed {
        t_func                  func;
        logic [IDX_W-1:0]       slot_index;
        logic [GEN_BITS-1:0]    handle_generation;
        logic [DATA_BITS-1:0]   item_value;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [IDX_W-1:0]       out_index;
        logic [GEN_BITS-1:0]    out_generation;
        logic [DATA_BITS-1:0]   out_value;
        logic [CNT_W-1:0]       live_count;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic     cap;       // latch request word
        logic     rd_slot;   // read slot tables, dense tables at last entry
        logic     rd_get;    // read payload at the slot's dense position
        logic     ins;       // commit insert
        logic     rem;       // commit remove
        logic     out_load;  // load result into output register
        t_res_sel res_sel;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_func func;
        logic  full;
        logic  handle_ok;
        logic  cnt_zero;
        logic  out_free;
    } t_stat;

endpackage

// ===== design/gsm_ctrl.sv =====
`timescale 1ns / 1ps

module gsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gsm_pkg::t_stat i_stat,
    output gsm_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_INS,
        S_CHK,
        S_GET,
        S_DONE
    } t_state;

    t_state            r_state;
    gsm_pkg::t_res_sel r_sel;

    logic w_rem_ok;

    assign w_rem_ok = i_stat.handle_ok && !i_stat.cnt_zero;
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.res_sel  = r_sel;
        case (r_state)
            S_IDLE: begin
                o_cmd.cap = i_valid;
            end
            S_LOOK: begin
                o_cmd.rd_slot = !(i_stat.func == gsm_pkg::FN_INSERT && i_stat.full);
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
            end
            S_CHK: begin
                o_cmd.rd_get = i_stat.handle_ok && (i_stat.func == gsm_pkg::FN_GET);
                o_cmd.rem    = w_rem_ok && (i_stat.func == gsm_pkg::FN_REMOVE);
            end
            S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= gsm_pkg::RES_BAD;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (i_stat.func == gsm_pkg::FN_INSERT) begin
                        if (i_stat.full) begin
                            r_sel   <= gsm_pkg::RES_FULL;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_INS;
                        end
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_INS: begin
                    r_sel   <= gsm_pkg::RES_INS;
                    r_state <= S_DONE;
                end
                S_CHK: begin
                    if (!i_stat.handle_ok) begin
                        r_sel   <= gsm_pkg::RES_BAD;
                        r_state <= S_DONE;
                    end else begin
                        case (i_stat.func)
                            gsm_pkg::FN_GET: begin
                                r_state <= S_GET;
                            end
                            gsm_pkg::FN_REMOVE: begin
                                r_sel   <= w_rem_ok ? gsm_pkg::RES_OK : gsm_pkg::RES_BAD;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_sel   <= gsm_pkg::RES_OK;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_GET: begin
                    r_sel   <= gsm_pkg::RES_GET;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/gsm_dpath.sv =====
`timescale 1ns / 1ps

module gsm_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gsm_pkg::t_req  i_req,
    input  gsm_pkg::t_cmd  i_cmd,
    output gsm_pkg::t_stat o_stat,
    output logic           o_valid,
    input  logic           i_ready,
    output gsm_pkg::t_rsp  o_rsp
);

    localparam int IDX_W = gsm_pkg::IDX_W;
    localparam int CNT_W = gsm_pkg::CNT_W;
    localparam int GW    = gsm_pkg::GEN_BITS;
    localparam int DW    = gsm_pkg::DATA_BITS;
    localparam int N     = gsm_pkg::SLOTS;

    // slot tables
    logic [GW-1:0]    gen_mem   [N];
    logic [CNT_W-1:0] next_mem  [N];
    logic [IDX_W-1:0] pos_mem   [N];
    // dense tables
    logic [IDX_W-1:0] owner_mem [N];
    logic [DW-1:0]    pay_mem   [N];

    // gen/next flags set once an entry has been written; unwritten entries read as reset value
    logic [N-1:0]     r_gen_wr;
    logic [N-1:0]     r_next_wr;
    logic [N-1:0]     r_live;

    logic [CNT_W-1:0] r_free_head;
    logic [CNT_W-1:0] r_count;
    gsm_pkg::t_req    r_req;
    logic [IDX_W-1:0] r_slot_addr;

    logic [GW-1:0]    r_gen_rd;
    logic             r_gen_wr_rd;
    logic [CNT_W-1:0] r_next_rd;
    logic             r_next_wr_rd;
    logic [IDX_W-1:0] r_pos_rd;
    logic [IDX_W-1:0] r_owner_rd;
    logic [DW-1:0]    r_pay_rd;

    logic             r_out_valid;
    gsm_pkg::t_rsp    r_out;

    logic [IDX_W-1:0] w_slot_ra;
    logic [IDX_W-1:0] w_last;
    logic [IDX_W-1:0] w_pay_ra;
    logic [GW-1:0]    w_gen;
    logic [CNT_W-1:0] w_next;
    logic [GW-1:0]    w_gen_inc;
    logic [GW-1:0]    w_gen_new;
    logic             w_move;
    logic             w_idx_ok;
    gsm_pkg::t_rsp    w_res;

    assign w_slot_ra = (r_req.func == gsm_pkg::FN_INSERT) ? r_free_head[IDX_W-1:0]
                                                          : r_req.slot_index;
    assign w_last    = r_count[IDX_W-1:0] - IDX_W'(1);
    assign w_pay_ra  = i_cmd.rd_get ? r_pos_rd : w_last;
    assign w_gen     = r_gen_wr_rd ? r_gen_rd : GW'(1);
    assign w_next    = r_next_wr_rd ? r_next_rd : (CNT_W'(r_slot_addr) + CNT_W'(1));
    assign w_gen_inc = w_gen + GW'(1);
    assign w_gen_new = (w_gen_inc == '0) ? GW'(1) : w_gen_inc;
    assign w_move    = (r_pos_rd != w_last);
    assign w_idx_ok  = (CNT_W'(r_req.slot_index) < CNT_W'(N));

    assign o_stat.func      = r_req.func;
    assign o_stat.full      = (r_count >= CNT_W'(N)) || (r_free_head >= CNT_W'(N));
    assign o_stat.handle_ok = (r_req.handle_generation != '0) && w_idx_ok
                              && r_live[r_req.slot_index]
                              && (w_gen == r_req.handle_generation);
    assign o_stat.cnt_zero  = (r_count == '0);
    assign o_stat.out_free  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) r_req <= i_req;
        if (i_cmd.rd_slot) r_slot_addr <= w_slot_ra;
    end

    // slot generation table
    always_ff @(posedge i_clk) begin
        if (i_cmd.rem) gen_mem[r_slot_addr] <= w_gen_new;
        if (i_cmd.rd_slot) r_gen_rd <= gen_mem[w_slot_ra];
    end

    // free-list links
    always_ff @(posedge i_clk) begin
        if (i_cmd.rem) next_mem[r_slot_addr] <= r_free_head;
        if (i_cmd.rd_slot) r_next_rd <= next_mem[w_slot_ra];
    end

    // dense position of each slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            pos_mem[r_slot_addr] <= r_count[IDX_W-1:0];
        end else if (i_cmd.rem && w_move) begin
            pos_mem[r_owner_rd] <= r_pos_rd;
        end
        if (i_cmd.rd_slot) r_pos_rd <= pos_mem[w_slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            owner_mem[r_count[IDX_W-1:0]] <= r_slot_addr;
        end else if (i_cmd.rem && w_move) begin
            owner_mem[r_pos_rd] <= r_owner_rd;
        end
        if (i_cmd.rd_slot) r_owner_rd <= owner_mem[w_last];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            pay_mem[r_count[IDX_W-1:0]] <= r_req.item_value;
        end else if (i_cmd.rem && w_move) begin
            pay_mem[r_pos_rd] <= r_pay_rd;
        end
        if (i_cmd.rd_slot || i_cmd.rd_get) r_pay_rd <= pay_mem[w_pay_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_wr     <= '0;
            r_next_wr    <= '0;
            r_live       <= '0;
            r_free_head  <= '0;
            r_count      <= '0;
            r_gen_wr_rd  <= 1'b0;
            r_next_wr_rd <= 1'b0;
        end else begin
            if (i_cmd.rd_slot) begin
                r_gen_wr_rd  <= r_gen_wr[w_slot_ra];
                r_next_wr_rd <= r_next_wr[w_slot_ra];
            end
            if (i_cmd.ins) begin
                r_live[r_slot_addr] <= 1'b1;
                r_free_head         <= w_next;
                r_count             <= r_count + CNT_W'(1);
            end else if (i_cmd.rem) begin
                r_live[r_slot_addr]    <= 1'b0;
                r_gen_wr[r_slot_addr]  <= 1'b1;
                r_next_wr[r_slot_addr] <= 1'b1;
                r_free_head            <= CNT_W'(r_slot_addr);
                r_count                <= r_count - CNT_W'(1);
            end
        end
    end

    always_comb begin
        w_res            = '0;
        w_res.live_count = r_count;
        case (i_cmd.res_sel)
            gsm_pkg::RES_FULL: begin
                w_res.status = gsm_pkg::ST_FULL;
            end
            gsm_pkg::RES_OK: begin
                w_res.status = gsm_pkg::ST_OK;
            end
            gsm_pkg::RES_INS: begin
                w_res.status         = gsm_pkg::ST_OK;
                w_res.out_index      = r_slot_addr;
                w_res.out_generation = w_gen;
            end
            gsm_pkg::RES_GET: begin
                w_res.status    = gsm_pkg::ST_OK;
                w_res.out_value = r_pay_rd;
            end
            default: begin
                w_res.status = gsm_pkg::ST_BAD;
            end
        endcase
    end

    // output register parts the result from the next request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) r_out <= w_res;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

// ===== design/generational_slot_map.sv =====
`timescale 1ns / 1ps
// channel   valid     ready     word
// request   i_valid   o_ready   i_req (gsm_pkg::t_req)
// response  o_valid   i_ready   o_rsp (gsm_pkg::t_rsp)
//
// One request at a time: accept, table lookup, commit, result. Insert, remove
// and alive pass lookup, commit or check, and result; get adds a second
// dependent read of the payload memory; a full-table insert goes from lookup
// straight to result. The registered-read slot and dense memories set the steps.
// Reset clears live, written and free-list state; no sweep.
// A stalled response sits in the output register; one further request is
// accepted and committed behind it, then holds its result and stalls input
// until the register frees.

module generational_slot_map (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gsm_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output gsm_pkg::t_rsp o_rsp
);

    gsm_pkg::t_cmd  w_cmd;
    gsm_pkg::t_stat w_stat;

    gsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gsm_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== design/gsm_check.sv =====
`timescale 1ns / 1ps

module gsm_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input gsm_pkg::t_req i_req,
    input logic          o_valid,
    input logic          i_ready,
    input gsm_pkg::t_rsp o_rsp
);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.live_count <= gsm_pkg::CNT_W'(gsm_pkg::SLOTS)))
        else $error("live count above capacity");

    // free list never runs dry while slots remain
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == gsm_pkg::ST_FULL)
        |-> (o_rsp.live_count == gsm_pkg::CNT_W'(gsm_pkg::SLOTS)))
        else $error("full reported below capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != gsm_pkg::ST_OK)
        |-> (o_rsp.out_index == '0 && o_rsp.out_generation == '0
             && o_rsp.out_value == '0))
        else $error("failed request carries handle or payload");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rsp)))
        else $error("stalled response word changed");

endmodule

bind generational_slot_map gsm_check u_gsm_check (.*);
